// File: sv/sgad_pkg.sv
// Shared types, register indexes and saturation helpers for the advection-diffusion block.
package sgad_pkg;

  // Neighborhood of one velocity component: centre, left, right, down, top, diagonal.
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] l;
    logic signed [31:0] r;
    logic signed [31:0] d;
    logic signed [31:0] t;
    logic signed [31:0] x;
  } sgad_nbr_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH   = 3'd0,
    REG_GRID_HEIGHT  = 3'd1,
    REG_CONV_X       = 3'd2,
    REG_CONV_Y       = 3'd3,
    REG_DIFF_X       = 3'd4,
    REG_DIFF_Y       = 3'd5,
    REG_LEFT_U_UPD   = 3'd6,
    REG_BOTTOM_V_UPD = 3'd7
  } sgad_reg_e;

  localparam int unsigned ENG_ISSUE = 16;
  localparam logic [4:0]  ENG_LAST  = 5'd18;

  function automatic logic signed [34:0] ext35(input logic signed [31:0] a);
    return 35'(a);
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
    if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) return x[31:0];
    return x[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    if (x[63:31] == '0 || x[63:31] == '1) return x[31:0];
    return x[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage

// File: sv/staggered_grid_advection_diffusion.sv
// Top level: raster input, line buffer memories, 3x3 window and result register.
//
// The block takes one padded grid point per input beat, in raster order from the bottom halo
// row, and for each point that completes an interior 3x3 neighborhood returns one beat with
// the new u and v of that cell (tlast on the final cell). A halo point is accepted, with its
// line buffer entry read, and then written back in ST_READ. An interior point goes on from
// ST_READ into ST_CALC for the 19 steps of the engine, which sends 16 products through one
// shared 32x32 multiplier with three pipeline registers. The input also waits while a finished
// result sits unclaimed in the output register. The line buffers need no clearing after reset.
module staggered_grid_advection_diffusion #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] u_value, [63:32] v_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] u_new, [63:32] v_new
  output logic        m_axis_tlast_o
);
  import sgad_pkg::*;

  localparam int LINE_LEN = MAX_WIDTH + 2;
  localparam int POS_W    = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_CALC = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [10:0] grid_w_q, grid_h_q;
  logic [30:0] conv_x_q, conv_y_q, diff_x_q, diff_y_q;
  logic        left_u_q, bottom_v_q;

  logic [POS_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [POS_W-1:0] w_lim;
  logic [ROW_W-1:0] h_lim;
  logic [31:0]      gw32, gh32, w_eff, h_eff;

  logic [63:0] u_mem [LINE_LEN];
  logic [63:0] v_mem [LINE_LEN];
  logic [63:0] u_rd_q, v_rd_q;
  logic signed [31:0] in_u_q, in_v_q;

  // Window columns 0..2 (left to right), rows 0..2 (bottom to top).
  logic signed [31:0] wu_q [3][3];
  logic signed [31:0] wv_q [3][3];

  logic        s_acc, emit, res_ready, eng_done;
  logic        upd_u_q, upd_v_q, last_q;
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        out_last_q;
  logic signed [31:0] eng_u, eng_v;
  sgad_nbr_t   u_nbr, v_nbr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q   <= 11'd1024;
      grid_h_q   <= 11'd1024;
      conv_x_q   <= '0;
      conv_y_q   <= '0;
      diff_x_q   <= '0;
      diff_y_q   <= '0;
      left_u_q   <= 1'b1;
      bottom_v_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (sgad_reg_e'(cfg_index_i))
        REG_GRID_WIDTH:   grid_w_q   <= cfg_data_i[10:0];
        REG_GRID_HEIGHT:  grid_h_q   <= cfg_data_i[10:0];
        REG_CONV_X:       conv_x_q   <= cfg_data_i;
        REG_CONV_Y:       conv_y_q   <= cfg_data_i;
        REG_DIFF_X:       diff_x_q   <= cfg_data_i;
        REG_DIFF_Y:       diff_y_q   <= cfg_data_i;
        REG_LEFT_U_UPD:   left_u_q   <= cfg_data_i[0];
        REG_BOTTOM_V_UPD: bottom_v_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sizes are clamped to the built line length and height.
  assign gw32  = 32'(grid_w_q);
  assign gh32  = 32'(grid_h_q);
  assign w_eff = (gw32 == 0) ? 32'd1 : ((gw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : gw32);
  assign h_eff = (gh32 == 0) ? 32'd1 : ((gh32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : gh32);
  assign w_lim = POS_W'(w_eff + 32'd1);
  assign h_lim = ROW_W'(h_eff + 32'd1);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign emit = (col_q >= POS_W'(2)) && (col_q <= w_lim) &&
                (row_q >= ROW_W'(2)) && (row_q <= h_lim);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_acc) state_d = ST_READ;
      ST_READ: state_d = emit ? ST_CALC : ST_IDLE;
      ST_CALC: if (eng_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_READ) begin
        if (col_q >= w_lim) begin
          col_q <= '0;
          row_q <= (row_q >= h_lim) ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + POS_W'(1);
        end
      end
    end
  end

  // Each entry holds the previous row in the low half and the row before it in the high half.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_u_q <= s_axis_tdata_i[31:0];
      in_v_q <= s_axis_tdata_i[63:32];
      u_rd_q <= u_mem[col_q];
      v_rd_q <= v_mem[col_q];
    end
    if (state_q == ST_READ) begin
      u_mem[col_q] <= {u_rd_q[31:0], in_u_q};
      v_mem[col_q] <= {v_rd_q[31:0], in_v_q};
      for (int k = 0; k < 3; k++) begin
        wu_q[0][k] <= wu_q[1][k];
        wu_q[1][k] <= wu_q[2][k];
        wv_q[0][k] <= wv_q[1][k];
        wv_q[1][k] <= wv_q[2][k];
      end
      wu_q[2][0] <= u_rd_q[63:32];
      wu_q[2][1] <= u_rd_q[31:0];
      wu_q[2][2] <= in_u_q;
      wv_q[2][0] <= v_rd_q[63:32];
      wv_q[2][1] <= v_rd_q[31:0];
      wv_q[2][2] <= in_v_q;
      upd_u_q <= (col_q != POS_W'(2)) || left_u_q;
      upd_v_q <= (row_q != ROW_W'(2)) || bottom_v_q;
      last_q  <= (col_q == w_lim) && (row_q == h_lim);
    end
  end

  assign u_nbr = '{c: wu_q[1][1], l: wu_q[0][1], r: wu_q[2][1],
                   d: wu_q[1][0], t: wu_q[1][2], x: wu_q[2][0]};
  assign v_nbr = '{c: wv_q[1][1], l: wv_q[0][1], r: wv_q[2][1],
                   d: wv_q[1][0], t: wv_q[1][2], x: wv_q[0][2]};

  assign res_ready = !out_valid_q || m_axis_tready_i;

  sgad_engine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     ((state_q == ST_READ) && emit),
    .res_ready_i (res_ready),
    .u_nbr_i     (u_nbr),
    .v_nbr_i     (v_nbr),
    .conv_x_i    (conv_x_q),
    .conv_y_i    (conv_y_q),
    .diff_x_i    (diff_x_q),
    .diff_y_i    (diff_y_q),
    .done_o      (eng_done),
    .u_new_o     (eng_u),
    .v_new_o     (eng_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done) begin
      out_data_q <= {(upd_v_q ? eng_v : wv_q[1][1]), (upd_u_q ? eng_u : wu_q[1][1])};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: sv/sgad_engine.sv
// Shared-multiplier sequencer that computes the new u and v of one interior cell.
module sgad_engine #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                res_ready_i,
  input  sgad_pkg::sgad_nbr_t u_nbr_i,
  input  sgad_pkg::sgad_nbr_t v_nbr_i,
  input  logic [30:0]         conv_x_i,
  input  logic [30:0]         conv_y_i,
  input  logic [30:0]         diff_x_i,
  input  logic [30:0]         diff_y_i,
  output logic                done_o,
  output logic signed [31:0]  u_new_o,
  output logic signed [31:0]  v_new_o
);
  import sgad_pkg::*;

  logic               busy_q;
  logic [4:0]         step_q;
  logic signed [31:0] opa_d, opb_d, opa_q, opb_q;
  logic               v1_q, v2_q;
  logic [3:0]         tag1_q, tag2_q;
  logic signed [63:0] prod_q, prod_sh;
  logic signed [31:0] m_q [ENG_ISSUE];
  logic signed [31:0] cx, cy, dx, dy;
  sgad_nbr_t          u, v;

  assign u  = u_nbr_i;
  assign v  = v_nbr_i;
  assign cx = $signed({1'b0, conv_x_i});
  assign cy = $signed({1'b0, conv_y_i});
  assign dx = $signed({1'b0, diff_x_i});
  assign dy = $signed({1'b0, diff_y_i});

  // Steps 0..7 form the convection products, 8..15 scale every term by its coefficient.
  always_comb begin
    opa_d = '0;
    opb_d = '0;
    case (step_q)
      5'd0: begin
        opa_d = u.r; opb_d = sat35(ext35(u.r) + ext35(u.c) + ext35(u.c));
      end
      5'd1: begin
        opa_d = u.l; opb_d = sat35(ext35(u.l) + ext35(u.c) + ext35(u.c));
      end
      5'd2: begin
        opa_d = sat35(ext35(u.c) + ext35(u.t)); opb_d = sat35(ext35(v.x) + ext35(v.t));
      end
      5'd3: begin
        opa_d = sat35(ext35(u.d) + ext35(u.c)); opb_d = sat35(ext35(v.l) + ext35(v.c));
      end
      5'd4: begin
        opa_d = sat35(ext35(v.c) + ext35(v.r)); opb_d = sat35(ext35(u.x) + ext35(u.r));
      end
      5'd5: begin
        opa_d = sat35(ext35(v.l) + ext35(v.c)); opb_d = sat35(ext35(u.d) + ext35(u.c));
      end
      5'd6: begin
        opa_d = v.t; opb_d = sat35(ext35(v.t) + ext35(v.c) + ext35(v.c));
      end
      5'd7: begin
        opa_d = v.d; opb_d = sat35(ext35(v.d) + ext35(v.c) + ext35(v.c));
      end
      5'd8: begin
        opa_d = cx; opb_d = sat35(ext35(m_q[0]) - ext35(m_q[1]));
      end
      5'd9: begin
        opa_d = cy; opb_d = sat35(ext35(m_q[2]) - ext35(m_q[3]));
      end
      5'd10: begin
        opa_d = dx; opb_d = sat35(ext35(u.r) + ext35(u.l) - ext35(u.c) - ext35(u.c));
      end
      5'd11: begin
        opa_d = dy; opb_d = sat35(ext35(u.t) + ext35(u.d) - ext35(u.c) - ext35(u.c));
      end
      5'd12: begin
        opa_d = cx; opb_d = sat35(ext35(m_q[4]) - ext35(m_q[5]));
      end
      5'd13: begin
        opa_d = cy; opb_d = sat35(ext35(m_q[6]) - ext35(m_q[7]));
      end
      5'd14: begin
        opa_d = dx; opb_d = sat35(ext35(v.r) + ext35(v.l) - ext35(v.c) - ext35(v.c));
      end
      5'd15: begin
        opa_d = dy; opb_d = sat35(ext35(v.t) + ext35(v.d) - ext35(v.c) - ext35(v.c));
      end
      default: begin
        opa_d = '0; opb_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == ENG_LAST) begin
          if (res_ready_i) busy_q <= 1'b0;
        end else begin
          step_q <= step_q + 5'd1;
        end
      end
      v1_q <= busy_q && !start_i && (step_q < 5'(ENG_ISSUE));
      v2_q <= v1_q;
    end
  end

  assign prod_sh = prod_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    tag1_q <= step_q[3:0];
    prod_q <= opa_q * opb_q;
    tag2_q <= tag1_q;
    if (v2_q) m_q[tag2_q] <= sat64(prod_sh);
  end

  assign u_new_o = sat35(ext35(u.c) - ext35(m_q[8]) - ext35(m_q[9])
                         + ext35(m_q[10]) + ext35(m_q[11]));
  assign v_new_o = sat35(ext35(v.c) - ext35(m_q[12]) - ext35(m_q[13])
                         + ext35(m_q[14]) + ext35(m_q[15]));
  assign done_o  = busy_q && (step_q == ENG_LAST) && res_ready_i;

endmodule

// File: sv/sgad_checker.sv
// Port-level checker for the advection-diffusion block and its bind.
module sgad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // The block works on one point at a time, so it cannot take two beats back to back.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input beat accepted in the cycle after another");

  // A result appears only after computation, never right after an input beat.
  a_result_not_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result appeared directly after an input beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

  // A clock edge seen in reset leaves the output without a valid beat.
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

endmodule

bind staggered_grid_advection_diffusion sgad_checker u_sgad_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
